[rtl/quarter_wave_trig_unit_core_macros.svh]
// quarter_wave_trig_unit_core_macros.svh: assertion macros for the trig unit checker
// depends on nothing; included by the checker file

`ifndef QUARTER_WAVE_TRIG_UNIT_CORE_MACROS_SVH
`define QUARTER_WAVE_TRIG_UNIT_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define QWTU_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define QWTU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/qwtu_pkg.sv]
// qwtu_pkg: constants, types and the quarter-wave sine table for the trig unit
// depends on nothing; imported by qwtu_ctrl, qwtu_dp, the top level and the checker

package qwtu_pkg;

    localparam int TABLE_DEPTH   = 1024;
    localparam int SAMPLE_BITS   = 16;
    localparam int IDX_W         = $clog2(TABLE_DEPTH);
    localparam int CNT_W         = IDX_W + 1;
    localparam int HALF_DEPTH    = TABLE_DEPTH / 2;
    localparam int WORK_BITS     = 30;
    localparam longint unsigned PI_WORK = 64'd3373259426;
    localparam int QUARTER_PHASE = 1024;
    localparam int BASE_W        = 14;
    localparam int VALUE_W       = 32;
    localparam int PHASE_W       = 12;
    localparam int COORD_W       = 32;
    localparam int FRAC_BITS     = 16;
    localparam int DIVD_W        = SAMPLE_BITS + FRAC_BITS;
    localparam int DIVC_W        = $clog2(DIVD_W + 1);
    localparam int PROD_W        = SAMPLE_BITS + COORD_W;
    localparam logic [VALUE_W-1:0] VALUE_MAX = 32'h7fff_ffff;

    typedef enum logic [1:0] {
        OP_SIN  = 2'd0,
        OP_COS  = 2'd1,
        OP_TAN  = 2'd2,
        OP_ATAN = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_FILL,
        ST_IDLE,
        ST_READ,
        ST_CALC,
        ST_DIV,
        ST_SCAN,
        ST_HOLD
    } t_state;

    typedef logic [SAMPLE_BITS-1:0] t_sample;
    typedef t_sample t_sine_table [TABLE_DEPTH];

    // controller to datapath
    typedef struct packed {
        logic fill;
        logic load;
        logic calc;
        logic div_step;
        logic scan;
        logic res_div;
        logic res_scan;
        logic push;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic fill_done;
        t_op  op;
        logic den_zero;
        logic div_done;
        logic scan_done;
        logic out_free;
    } t_dp_stat;

    // shift and subtract long division, only used while building the table
    function automatic longint unsigned udiv64(longint unsigned a, longint unsigned d);
        longint unsigned q;
        longint unsigned r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[62:0], a[b]};
            if (r >= d) begin
                r    = r - d;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // sin(i*pi/(2*depth)) by taylor series in q30, rounded and clamped
    function automatic t_sample sine_entry(int unsigned i);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned v;
        longint unsigned top;
        longint          sum;
        int              shift;
        x     = (64'(i) * PI_WORK + 64'(TABLE_DEPTH)) >> (IDX_W + 1);
        x2    = (x * x) >> WORK_BITS;
        term  = x;
        sum   = longint'(x);
        shift = WORK_BITS - (SAMPLE_BITS - 1);
        top   = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;
        for (int k = 1; k <= 10; k++) begin
            term = udiv64((term * x2) >> WORK_BITS, 64'((2 * k) * (2 * k + 1)));
            if ((k & 1) == 1) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        v = (64'(sum) + (64'd1 << (shift - 1))) >> shift;
        if (v > top) begin
            v = top;
        end
        return SAMPLE_BITS'(v);
    endfunction

    function automatic t_sine_table build_table();
        t_sine_table t;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            t[i] = sine_entry(i);
        end
        return t;
    endfunction

    localparam t_sine_table SINE_TABLE = build_table();

endpackage

[rtl/qwtu_ram.sv]
// qwtu_ram: generic single-write, dual-read ram with registered read data
// depends on nothing

module qwtu_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

[rtl/qwtu_ctrl.sv]
// qwtu_ctrl: sequencer of the trig unit (table fill, read, divide, scan, hand-off)
// depends on qwtu_pkg

module qwtu_ctrl
    import qwtu_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_FILL;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_FILL: begin
                if (i_stat.fill_done) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_READ;
            end
            ST_READ: begin
                n_state = (i_stat.op == OP_ATAN) ? ST_SCAN : ST_CALC;
            end
            ST_CALC: begin
                if (i_stat.op == OP_TAN && !i_stat.den_zero) begin
                    n_state = ST_DIV;
                end else begin
                    n_state = ST_HOLD;
                end
            end
            ST_DIV: begin
                if (i_stat.div_done) n_state = ST_HOLD;
            end
            ST_SCAN: begin
                if (i_stat.scan_done) n_state = ST_HOLD;
            end
            ST_HOLD: begin
                if (i_stat.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_FILL;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            ST_FILL: begin
                o_cmd.fill = !i_stat.fill_done;
            end
            ST_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            ST_CALC: begin
                o_cmd.calc = 1'b1;
            end
            ST_DIV: begin
                o_cmd.div_step = !i_stat.div_done;
                o_cmd.res_div  = i_stat.div_done;
            end
            ST_SCAN: begin
                o_cmd.scan     = 1'b1;
                o_cmd.res_scan = i_stat.scan_done;
            end
            ST_HOLD: begin
                o_cmd.push = i_stat.out_free;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

endmodule

[rtl/qwtu_dp.sv]
// qwtu_dp: datapath of the trig unit: sine table ram, quadrant logic, divider,
// atan2 scan pipeline and output register; depends on qwtu_pkg and qwtu_ram

module qwtu_dp
    import qwtu_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_dp_cmd                   i_cmd,
    output t_dp_stat                  o_stat,
    input  logic [1:0]                i_command,
    input  logic [PHASE_W-1:0]        i_phase,
    input  logic signed [COORD_W-1:0] i_y_coord,
    input  logic signed [COORD_W-1:0] i_x_coord,
    input  logic                      i_out_stall,
    output logic                      o_out_valid,
    output logic signed [VALUE_W-1:0] o_value,
    output logic                      o_saturated
);

    // table fill
    logic [CNT_W-1:0]       r_fill_cnt;
    // captured item
    t_op                    r_op;
    logic [1:0]             r_quad;
    logic [IDX_W-1:0]       r_ptr;
    logic [COORD_W-1:0]     r_x1;
    logic [COORD_W-1:0]     r_y1;
    logic [BASE_W-1:0]      r_base;
    logic                   r_dir_neg;
    // divider
    logic [SAMPLE_BITS-1:0] r_den;
    logic [SAMPLE_BITS-1:0] r_rem;
    logic [DIVD_W-1:0]      r_q;
    logic [DIVC_W-1:0]      r_div_cnt;
    // scan pipeline
    logic                   r_v1;
    logic                   r_v2;
    logic [IDX_W-2:0]       r_tag1;
    logic [IDX_W-2:0]       r_tag2;
    logic [PROD_W-1:0]      r_lhs;
    logic [PROD_W-1:0]      r_rhs;
    // result and output
    logic signed [VALUE_W-1:0] r_res_val;
    logic                      r_res_sat;
    logic                      r_out_valid;
    logic signed [VALUE_W-1:0] r_out_val;
    logic                      r_out_sat;

    t_sample rd_fwd;
    t_sample rd_rev;

    qwtu_ram #(
        .WIDTH(SAMPLE_BITS),
        .DEPTH(TABLE_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (i_cmd.fill),
        .i_waddr   (r_fill_cnt[IDX_W-1:0]),
        .i_wdata   (SINE_TABLE[r_fill_cnt[IDX_W-1:0]]),
        .i_raddr_a (r_ptr),
        .i_raddr_b (~r_ptr),
        .o_rdata_a (rd_fwd),
        .o_rdata_b (rd_rev)
    );

    // octant fold of (y, x)
    logic signed [COORD_W:0] y_ext;
    logic signed [COORD_W:0] x_ext;
    logic signed [COORD_W:0] fx;
    logic signed [COORD_W:0] fy;
    logic [COORD_W-1:0]      ux;
    logic [COORD_W-1:0]      uy;
    logic [BASE_W-1:0]       fbase;
    logic [BASE_W-1:0]       n_base;
    logic [COORD_W-1:0]      n_x1;
    logic [COORD_W-1:0]      n_y1;
    logic                    n_dir_neg;

    always_comb begin
        y_ext = {i_y_coord[COORD_W-1], i_y_coord};
        x_ext = {i_x_coord[COORD_W-1], i_x_coord};
        fx    = x_ext;
        fy    = y_ext;
        fbase = '0;
        if (x_ext < 0) begin
            if (y_ext >= 0) begin
                fbase = BASE_W'(QUARTER_PHASE);
                fx    = y_ext;
                fy    = -x_ext;
            end else begin
                fbase = BASE_W'(2 * QUARTER_PHASE);
                fx    = -x_ext;
                fy    = -y_ext;
            end
        end else if (y_ext < 0) begin
            fbase = BASE_W'(3 * QUARTER_PHASE);
            fx    = -y_ext;
            fy    = x_ext;
        end
        ux = fx[COORD_W-1:0];
        uy = fy[COORD_W-1:0];
        if (uy > ux) begin
            n_base    = fbase + BASE_W'(QUARTER_PHASE);
            n_x1      = uy;
            n_y1      = ux;
            n_dir_neg = 1'b1;
        end else begin
            n_base    = fbase;
            n_x1      = ux;
            n_y1      = uy;
            n_dir_neg = 1'b0;
        end
    end

    // sine / cosine / tangent operands from the two table reads
    logic signed [VALUE_W-1:0] fwd_s;
    logic signed [VALUE_W-1:0] rev_s;
    logic signed [VALUE_W-1:0] trig_val;
    logic                      tan_neg;
    t_sample                   num;
    t_sample                   den;
    logic [DIVD_W-1:0]         dividend;

    always_comb begin
        fwd_s = VALUE_W'(rd_fwd);
        rev_s = VALUE_W'(rd_rev);
        if (r_op == OP_SIN) begin
            case (r_quad)
                2'd0:    trig_val = fwd_s;
                2'd1:    trig_val = rev_s;
                2'd2:    trig_val = -fwd_s;
                default: trig_val = -rev_s;
            endcase
        end else begin
            case (r_quad)
                2'd0:    trig_val = rev_s;
                2'd1:    trig_val = -fwd_s;
                2'd2:    trig_val = -rev_s;
                default: trig_val = fwd_s;
            endcase
        end
        tan_neg  = r_quad[0];
        num      = tan_neg ? rd_rev : rd_fwd;
        den      = tan_neg ? rd_fwd : rd_rev;
        dividend = {num, FRAC_BITS'(0)} + DIVD_W'(den >> 1);
    end

    // restoring division step
    logic [SAMPLE_BITS+1:0] trial;
    always_comb begin
        trial = {1'b0, r_rem, r_q[DIVD_W-1]} - {2'b00, r_den};
    end

    // divider result with clamp
    logic                      div_sat;
    logic [VALUE_W-1:0]        div_mag;
    logic signed [VALUE_W-1:0] div_val;
    always_comb begin
        div_sat = 64'(r_q) > 64'(VALUE_MAX);
        div_mag = div_sat ? VALUE_MAX : VALUE_W'(r_q);
        div_val = tan_neg ? -$signed(div_mag) : $signed(div_mag);
    end

    // scan compare and atan2 result
    logic                      issue_ok;
    logic                      hit;
    logic                      exhausted;
    logic                      x_zero;
    logic [IDX_W-1:0]          scan_i;
    logic [BASE_W-1:0]         scan_phase;
    always_comb begin
        issue_ok   = !r_ptr[IDX_W-1];
        hit        = r_v2 && (r_lhs > r_rhs);
        exhausted  = !issue_ok && !r_v1 && !r_v2;
        x_zero     = (r_x1 == '0);
        scan_i     = hit ? {1'b0, r_tag2} : IDX_W'(HALF_DEPTH);
        if (x_zero) begin
            scan_phase = r_base;
        end else if (r_dir_neg) begin
            scan_phase = r_base - BASE_W'(scan_i);
        end else begin
            scan_phase = r_base + BASE_W'(scan_i);
        end
    end

    always_comb begin
        o_stat.fill_done = r_fill_cnt[IDX_W];
        o_stat.op        = r_op;
        o_stat.den_zero  = (den == '0);
        o_stat.div_done  = (r_div_cnt == '0);
        o_stat.scan_done = x_zero || hit || exhausted;
        o_stat.out_free  = !r_out_valid || !i_out_stall;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_cnt  <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.fill) begin
                r_fill_cnt <= r_fill_cnt + CNT_W'(1);
            end
            if (i_cmd.load) begin
                r_v1 <= 1'b0;
                r_v2 <= 1'b0;
            end else begin
                r_v1 <= i_cmd.scan && issue_ok;
                r_v2 <= r_v1;
            end
            if (i_cmd.push) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op      <= t_op'(i_command);
            r_quad    <= 2'(i_phase >> IDX_W);
            r_ptr     <= (t_op'(i_command) == OP_ATAN) ? '0 : IDX_W'(i_phase);
            r_x1      <= n_x1;
            r_y1      <= n_y1;
            r_base    <= n_base;
            r_dir_neg <= n_dir_neg;
        end else if (i_cmd.scan && issue_ok) begin
            r_ptr <= r_ptr + IDX_W'(1);
        end
        r_tag1 <= r_ptr[IDX_W-2:0];
        r_tag2 <= r_tag1;
        r_lhs  <= PROD_W'(rd_fwd) * PROD_W'(r_x1);
        r_rhs  <= PROD_W'(r_y1) * PROD_W'(rd_rev);

        if (i_cmd.calc) begin
            r_den     <= den;
            r_rem     <= '0;
            r_q       <= dividend;
            r_div_cnt <= DIVC_W'(DIVD_W);
            if (r_op == OP_TAN) begin
                r_res_val <= tan_neg ? -$signed(VALUE_MAX) : $signed(VALUE_MAX);
                r_res_sat <= 1'b1;
            end else begin
                r_res_val <= trig_val;
                r_res_sat <= 1'b0;
            end
        end else if (i_cmd.div_step) begin
            r_div_cnt <= r_div_cnt - DIVC_W'(1);
            if (!trial[SAMPLE_BITS+1]) begin
                r_rem <= trial[SAMPLE_BITS-1:0];
                r_q   <= {r_q[DIVD_W-2:0], 1'b1};
            end else begin
                r_rem <= {r_rem[SAMPLE_BITS-2:0], r_q[DIVD_W-1]};
                r_q   <= {r_q[DIVD_W-2:0], 1'b0};
            end
        end else if (i_cmd.res_div) begin
            r_res_val <= div_val;
            r_res_sat <= div_sat;
        end else if (i_cmd.res_scan) begin
            r_res_val <= VALUE_W'(scan_phase);
            r_res_sat <= 1'b0;
        end

        if (i_cmd.push) begin
            r_out_val <= r_res_val;
            r_out_sat <= r_res_sat;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_value     = r_out_val;
    assign o_saturated = r_out_sat;

endmodule

[rtl/quarter_wave_trig_unit_core.sv]
// quarter_wave_trig_unit_core: top level of the quarter-wave sine table trig unit
// depends on qwtu_pkg, qwtu_ctrl, qwtu_dp (and qwtu_ram inside the datapath)
//
// usage:
//   input channel (i_in_valid / o_in_stall) carries one item: i_command
//   (0 sine, 1 cosine, 2 tangent, 3 atan2), i_phase for the first three,
//   i_y_coord / i_x_coord for atan2. output channel (o_out_valid /
//   i_out_stall) returns one item per input item: o_value, o_saturated.
//   after reset the table ram is filled from the package table, one entry
//   per cycle, with o_in_stall held high the whole time.
//   one item is worked on at a time: sine and cosine go from the table
//   read to the result; tangent adds a 32-step restoring divider and a
//   result step, both skipped when the divisor is zero; atan2 skips the
//   scan at the origin, else scans one table pair per cycle through the
//   scan pipeline (two ram reads, two multiplies, one compare). the next
//   item is taken once the result is pushed. a finished result sits in
//   the output register; the next item is taken while it waits. if the
//   receiver stalls, the output holds, and a second finished result waits
//   in the datapath until the register frees up.

module quarter_wave_trig_unit_core
    import qwtu_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // input item
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [1:0]                i_command,
    input  logic [PHASE_W-1:0]        i_phase,
    input  logic signed [COORD_W-1:0] i_y_coord,
    input  logic signed [COORD_W-1:0] i_x_coord,
    // result item
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic signed [VALUE_W-1:0] o_value,
    output logic                      o_saturated
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // sequencer: fill, read, divide or scan, then hand-off
    qwtu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    // table, arithmetic and output register
    qwtu_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat),
        .i_command   (i_command),
        .i_phase     (i_phase),
        .i_y_coord   (i_y_coord),
        .i_x_coord   (i_x_coord),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_value     (o_value),
        .o_saturated (o_saturated)
    );

endmodule

[rtl/qwtu_checker.sv]
// qwtu_checker: port-level assertions for the trig unit, bound to the top level
// depends on qwtu_pkg and quarter_wave_trig_unit_core_macros.svh

`include "quarter_wave_trig_unit_core_macros.svh"

module qwtu_checker
    import qwtu_pkg::*;
(
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      o_in_stall,
    input logic                      o_out_valid,
    input logic                      i_out_stall,
    input logic signed [VALUE_W-1:0] o_value,
    input logic                      o_saturated
);

    `QWTU_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_value) && $stable(o_saturated), "stalled result changed")
    `QWTU_ASSERT_NEXT(a_one_item, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall, "second item taken while busy")
    `QWTU_ASSERT_IMPL(a_sat_clamp, i_clk, i_rst_n, o_out_valid && o_saturated, o_value == $signed(VALUE_MAX) || o_value == -$signed(VALUE_MAX), "saturated result not clamped")
    `QWTU_ASSERT_IMPL(a_push_busy, i_clk, i_rst_n, $rose(o_out_valid), $past(o_in_stall), "result appeared without work")

endmodule

bind quarter_wave_trig_unit_core qwtu_checker u_qwtu_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_value     (o_value),
    .o_saturated (o_saturated)
);

[tb/sv/quarter_wave_trig_unit_core_tb.sv]
// quarter_wave_trig_unit_core_tb: self-checking bench for the quarter-wave trig unit
// depends on qwtu_pkg and quarter_wave_trig_unit_core; predicts results from its own sine table

module quarter_wave_trig_unit_core_tb
    import qwtu_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 40000;  // fill pass plus long scans and stalls

    typedef struct {
        t_op                      op;
        logic [PHASE_W-1:0]       phase;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } t_trig_item;

    typedef struct {
        logic signed [VALUE_W-1:0] value;
        logic                      sat;
    } t_trig_result;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_stall;
    logic [1:0]                 command;
    logic [PHASE_W-1:0]         phase;
    logic signed [COORD_W-1:0]  y_coord;
    logic signed [COORD_W-1:0]  x_coord;
    logic                       out_valid;
    logic                       out_stall;
    logic signed [VALUE_W-1:0]  value;
    logic                       saturated;

    t_trig_item   pending_items[$];
    t_trig_result expected_results[$];
    longint unsigned sine_lut[TABLE_DEPTH];
    int  error_count;
    int  idle_cycles;
    bit  stim_done;
    bit  hold_sender;   // sender pause until every expected result is back
    int  burst_left;
    int  gap_left;
    int  stall_mode;

    quarter_wave_trig_unit_core i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_command  (command),
        .i_phase    (phase),
        .i_y_coord  (y_coord),
        .i_x_coord  (x_coord),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_value    (value),
        .o_saturated(saturated)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // quarter-wave table from a q30 taylor series, rounded and clamped
    function automatic longint unsigned table_sample(int unsigned i);
        longint unsigned ang;
        longint unsigned ang2;
        longint unsigned term;
        longint unsigned rounded;
        longint          acc;
        ang  = (64'(i) * 64'd3373259426 + 64'd1024) / 64'd2048;
        ang2 = (ang * ang) >> 30;
        term = ang;
        acc  = longint'(ang);
        for (int k = 1; k <= 10; k++) begin
            term = ((term * ang2) >> 30) / 64'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) acc -= longint'(term);
            else acc += longint'(term);
        end
        if (acc < 0) acc = 0;
        rounded = (64'(acc) + 64'd16384) >> 15;
        if (rounded > 64'd32767) rounded = 64'd32767;
        return rounded;
    endfunction

    // expected result of one item
    function automatic t_trig_result trig_expected(t_trig_item it);
        t_trig_result r;
        int unsigned idx;
        int unsigned quad;
        longint fwd, rev, v, base, dir, xs, ys, xf, yf, tmp;
        longint unsigned num, den, q;
        int unsigned i;
        idx  = it.phase % TABLE_DEPTH;
        quad = (it.phase / TABLE_DEPTH) % 4;
        fwd  = longint'(sine_lut[idx]);
        rev  = longint'(sine_lut[TABLE_DEPTH - 1 - idx]);
        v    = 0;
        r.sat = 1'b0;
        case (it.op)
            OP_SIN: v = (quad == 0) ? fwd : (quad == 1) ? rev : (quad == 2) ? -fwd : -rev;
            OP_COS: v = (quad == 0) ? rev : (quad == 1) ? -fwd : (quad == 2) ? -rev : fwd;
            OP_TAN: begin
                num = (quad % 2 == 1) ? rev : fwd;
                den = (quad % 2 == 1) ? fwd : rev;
                if (den == 0) begin
                    q = 64'h7fff_ffff;
                    r.sat = 1'b1;
                end else begin
                    q = ((num << 16) + den / 2) / den;
                    if (q > 64'h7fff_ffff) begin
                        q = 64'h7fff_ffff;
                        r.sat = 1'b1;
                    end
                end
                v = (quad % 2 == 1) ? -longint'(q) : longint'(q);
            end
            default: begin
                ys = it.y;
                xs = it.x;
                xf = xs;
                yf = ys;
                base = 0;
                dir = 1;
                // fold into octant 0
                if (xs < 0) begin
                    if (ys >= 0) begin
                        base = QUARTER_PHASE; xf = ys; yf = -xs;
                    end else begin
                        base = 2 * QUARTER_PHASE; xf = -xs; yf = -ys;
                    end
                end else if (ys < 0) begin
                    base = 3 * QUARTER_PHASE; xf = -ys; yf = xs;
                end
                if (yf > xf) begin
                    base += QUARTER_PHASE;
                    tmp = xf; xf = yf; yf = tmp;
                    dir = -1;
                end
                if (xf == 0) begin
                    v = base;
                end else begin
                    for (i = 0; i < TABLE_DEPTH / 2; i++) begin
                        if (sine_lut[i] * 64'(xf) > 64'(yf) * sine_lut[TABLE_DEPTH - 1 - i])
                            break;
                    end
                    v = base + dir * longint'(i);
                end
            end
        endcase
        r.value = v[VALUE_W-1:0];
        return r;
    endfunction

    function automatic logic signed [COORD_W-1:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 20) - 10;
            1: return $urandom_range(0, 2000) - 1000;
            2: return $urandom;
            3: return 32'sh8000_0000 + $urandom_range(0, 3);
            default: return ($urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0001)
                            - $urandom_range(0, 1000);
        endcase
    endfunction

    function automatic t_trig_item make_item(t_op op, int unsigned ph, int y, int x);
        t_trig_item it;
        it.op = op;
        it.phase = ph[PHASE_W-1:0];
        it.y = y;
        it.x = x;
        return it;
    endfunction

    // stimulus: directed corners, then random items
    initial begin
        t_trig_item it;
        int m;
        for (int i = 0; i < TABLE_DEPTH; i++) sine_lut[i] = table_sample(i);
        // sine and cosine at quadrant edges, including the mirrored-index quirk
        pending_items.push_back(make_item(OP_SIN, 0, 0, 0));
        pending_items.push_back(make_item(OP_SIN, 1023, 0, 0));
        pending_items.push_back(make_item(OP_SIN, 1024, 0, 0));
        pending_items.push_back(make_item(OP_COS, 2048, 0, 0));
        pending_items.push_back(make_item(OP_COS, 3072, 0, 0));
        pending_items.push_back(make_item(OP_COS, 4095, 0, 0));
        // tangent with zero divisor and zero numerator
        pending_items.push_back(make_item(OP_TAN, 1024, 0, 0));
        pending_items.push_back(make_item(OP_TAN, 3072, 0, 0));
        pending_items.push_back(make_item(OP_TAN, 1023, 0, 0));
        pending_items.push_back(make_item(OP_TAN, 2047, 0, 0));
        pending_items.push_back(make_item(OP_TAN, 0, 0, 0));
        // atan2: origin, diagonals, axes, most negative value
        pending_items.push_back(make_item(OP_ATAN, 0, 0, 0));
        pending_items.push_back(make_item(OP_ATAN, 0, 5, 5));
        pending_items.push_back(make_item(OP_ATAN, 0, -7, -7));
        pending_items.push_back(make_item(OP_ATAN, 0, 0, -3));
        pending_items.push_back(make_item(OP_ATAN, 0, -9, 0));
        pending_items.push_back(make_item(OP_ATAN, 0, 32'sh8000_0000, 32'sh8000_0000));
        pending_items.push_back(make_item(OP_ATAN, 0, 32'sh7fff_ffff, 32'sh8000_0000));
        pending_items.push_back(make_item(OP_ATAN, 4095, 1, 32'sh7fff_ffff));
        pending_items.push_back(make_item(OP_ATAN, 0, -1, 32'sh7fff_ffff));
        // drain here: the sender idles until all results are in
        while (pending_items.size() != 0) @(posedge clk);
        hold_sender = 1'b1;
        while (expected_results.size() != 0) @(posedge clk);
        hold_sender = 1'b0;
        for (int n = 0; n < 1150; n++) begin
            m = $urandom_range(0, 3);
            it.op = t_op'(m);
            it.phase = PHASE_W'($urandom);
            if ($urandom_range(0, 3) == 0)
                it.phase = PHASE_W'($urandom_range(0, 3) * 1024 + $urandom_range(0, 1) * 1023
                                    + $urandom_range(0, 2) - 1);
            it.y = rand_coord();
            it.x = rand_coord();
            if (it.op != OP_ATAN && $urandom_range(0, 1)) begin
                it.y = $urandom; it.x = $urandom;
            end
            pending_items.push_back(it);
            while (pending_items.size() > 8) @(posedge clk);
        end
        stim_done = 1'b1;
    end

    // driver: bursts of items with random gaps
    always @(posedge clk) begin
        t_trig_item it;
        if (!rst_n) begin
            in_valid <= 1'b0;
            burst_left <= 0;
            gap_left <= 0;
        end else if (!(in_valid && in_stall)) begin
            if (in_valid) void'(pending_items.pop_front());
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end else if (pending_items.size() > 0 && !hold_sender) begin
                it = pending_items[0];
                in_valid <= 1'b1;
                command  <= it.op;
                phase    <= it.phase;
                y_coord  <= it.y;
                x_coord  <= it.x;
                expected_results.push_back(trig_expected(it));
                if (burst_left == 0) begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left   <= $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 30);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver stall pattern and result check
    always @(posedge clk) begin
        t_trig_result exp_r;
        if (!rst_n) begin
            out_stall <= 1'b0;
            stall_mode <= 0;
        end else begin
            if (out_valid && !out_stall) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result value=%0d", value);
                    error_count++;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (value !== exp_r.value) begin
                        $error("value expected %0d actual %0d", exp_r.value, value);
                        error_count++;
                    end
                    if (saturated !== exp_r.sat) begin
                        $error("saturated expected %0b actual %0b", exp_r.sat, saturated);
                        error_count++;
                    end
                end
            end
            if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                2: out_stall <= ($urandom_range(0, 1) == 0);
                default: out_stall <= ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    // watchdog on cycles with no handshake
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        command = '0;
        phase = '0;
        y_coord = '0;
        x_coord = '0;
        error_count = 0;
        idle_cycles = 0;
        stim_done = 1'b0;
        hold_sender = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        fork
            begin
                while (!(stim_done && pending_items.size() == 0 && !in_valid
                         && expected_results.size() == 0)) @(posedge clk);
                repeat (600) @(posedge clk);
            end
            begin
                wait (idle_cycles >= IDLE_LIMIT);
                error_count++;
                $display("watchdog: no progress in %0d cycles", IDLE_LIMIT);
            end
        join_any
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
